// ===== sv/rgbenc_pkg.sv =====
package rgbenc_pkg;

	localparam int IDX_W       = 6;
	localparam int STORE_DEPTH = 64;
	localparam int CODE_W      = 48;

	localparam logic [1:0] CMD_SET  = 2'd0;
	localparam logic [1:0] CMD_FILL = 2'd1;
	localparam logic [1:0] CMD_SHOW = 2'd2;

	localparam logic [CODE_W-1:0] LINE_MASK = 48'hC30C30C30C30;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [IDX_W-1:0] led_index;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]  pixel_number;
		logic [CODE_W-1:0] green_code;
		logic [CODE_W-1:0] red_code;
		logic [CODE_W-1:0] blue_code;
		logic              last;
	} pix_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	// each data bit d becomes 1,1,d,d,0,0 on the line
	function automatic logic [CODE_W-1:0] expand_byte(input logic [7:0] v);
		logic [CODE_W-1:0] word;
		word = LINE_MASK;
		for (int k = 0; k < 8; k++) begin
			word[6*k+2] = word[6*k+2] | v[k];
			word[6*k+3] = word[6*k+3] | v[k];
		end
		return word;
	endfunction

endpackage

// ===== sv/rgbenc_ram.sv =====
module rgbenc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/rgb_led_strip_serial_encoder_unit.sv =====
// Serial line encoder for an addressable RGB LED strip. A set command writes one pixel as
// it is accepted; a fill walks the store at one pixel a cycle over entries 0 to LED_COUNT-1;
// a show reads the store through its single read port, one pixel a cycle while the output
// is not stalled, and delivers LED_COUNT results in index order (last marked), each with its
// green, red and blue bytes expanded into 48-bit line words sent MSB first. Fill and show
// accept no new command until they finish. The store comes out of reset cleared through
// per-entry valid bits, so no clearing pass is needed.
module rgb_led_strip_serial_encoder_unit #(
	parameter int LED_COUNT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  rgbenc_pkg::cmd_t   cmd_data,
	output logic               pix_valid,
	input  logic               pix_stall,
	output rgbenc_pkg::pix_t   pix_data
);

	localparam int IDX_W = rgbenc_pkg::IDX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
	localparam logic [IDX_W:0] COUNT_EXT = (IDX_W+1)'(LED_COUNT);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_SHOW = 2'd2;

	logic [1:0]                        state_q;
	logic [IDX_W-1:0]                  addr_q;
	logic                              issue_done_q;
	logic [rgbenc_pkg::STORE_DEPTH-1:0] valid_q;
	rgbenc_pkg::color_t                fill_q;

	logic                              v_s1;
	logic                              vbit_s1;
	logic                              last_s1;
	logic [IDX_W-1:0]                  idx_s1;

	logic                              out_valid_q;
	rgbenc_pkg::pix_t                  out_q;

	logic                              cmd_acc;
	logic                              advance;
	logic                              in_range;
	logic                              we;
	logic [IDX_W-1:0]                  waddr;
	rgbenc_pkg::color_t                wdata;
	logic                              re;
	rgbenc_pkg::color_t                rdata;
	rgbenc_pkg::color_t                px;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign advance   = !out_valid_q || !pix_stall;
	assign in_range  = {1'b0, cmd_data.led_index} < COUNT_EXT;
	assign re        = (state_q == ST_SHOW) && !issue_done_q && advance;

	always_comb begin
		we    = 1'b0;
		waddr = cmd_data.led_index;
		wdata = '{red: cmd_data.red, green: cmd_data.green, blue: cmd_data.blue};
		if (cmd_acc && cmd_data.cmd == rgbenc_pkg::CMD_SET && in_range) begin
			we = 1'b1;
		end
		if (state_q == ST_FILL) begin
			we    = 1'b1;
			waddr = addr_q;
			wdata = fill_q;
		end
	end

	rgbenc_ram #(
		.WIDTH($bits(rgbenc_pkg::color_t)),
		.DEPTH(rgbenc_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(addr_q),
		.rdata(rdata)
	);

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			valid_q      <= '0;
			v_s1         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (advance) begin
				v_s1        <= re;
				out_valid_q <= v_s1;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						case (cmd_data.cmd)
							rgbenc_pkg::CMD_FILL: begin
								state_q <= ST_FILL;
								addr_q  <= '0;
							end
							rgbenc_pkg::CMD_SHOW: begin
								state_q      <= ST_SHOW;
								addr_q       <= '0;
								issue_done_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					addr_q <= addr_q + IDX_W'(1);
					if (addr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SHOW: begin
					if (re) begin
						addr_q <= addr_q + IDX_W'(1);
						if (addr_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end
					end
					if (issue_done_q && (!v_s1 || advance)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// never-written entries read as a cleared pixel
	assign px = vbit_s1 ? rdata : '0;

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			fill_q <= '{red: cmd_data.red, green: cmd_data.green, blue: cmd_data.blue};
		end
		if (re) begin
			idx_s1  <= addr_q;
			last_s1 <= (addr_q == LAST_IDX);
			vbit_s1 <= valid_q[addr_q];
		end
		if (advance && v_s1) begin
			out_q.pixel_number <= idx_s1;
			out_q.green_code   <= rgbenc_pkg::expand_byte(px.green);
			out_q.red_code     <= rgbenc_pkg::expand_byte(px.red);
			out_q.blue_code    <= rgbenc_pkg::expand_byte(px.blue);
			out_q.last         <= last_s1;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix_data  = out_q;

	a_no_write_in_show: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHOW) |-> !we)
		else $error("store written during show");

	a_fill_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> we && waddr == addr_q)
		else $error("fill sweep skipped a write");

	a_read_in_show: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_SHOW))
		else $error("read data pending outside show");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_data.last) |-> (pix_data.pixel_number == LAST_IDX))
		else $error("last marked on wrong pixel");

	a_show_done_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHOW && issue_done_q) |-> !re)
		else $error("read issued after final pixel");

endmodule

// ===== verif/tb.sv =====
module tb;

	localparam int LED_COUNT = 64;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_CMDS = 194;
	localparam int HOLD_AT = 100;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int TIMEOUT_CYCLES = 1_500_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	rgbenc_pkg::cmd_t cmd_data = '0;
	logic pix_valid;
	logic pix_stall = 1'b0;
	rgbenc_pkg::pix_t pix_data;

	rgbenc_pkg::cmd_t queued_cmds[$];
	rgbenc_pkg::pix_t pending_pixels[$];
	rgbenc_pkg::color_t strip [LED_COUNT];
	rgbenc_pkg::pix_t exp_pix;
	int errors, n_set, n_fill, n_show, n_ignored, n_pixels, n_offered;
	int send_gap, hold_cnt, hold_len;

	rgb_led_strip_serial_encoder_unit #(
		.LED_COUNT(LED_COUNT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data (cmd_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_data (pix_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// msb first, each data bit as 1,1,d,d,0,0
	function automatic logic [rgbenc_pkg::CODE_W-1:0] line_code(input logic [7:0] v);
		logic [rgbenc_pkg::CODE_W-1:0] code;
		code = '0;
		for (int k = 7; k >= 0; k--)
			code = {code[rgbenc_pkg::CODE_W-7:0], 2'b11, {2{v[k]}}, 2'b00};
		return code;
	endfunction

	function automatic int draw_wait(input bit calm);
		if (calm)
			return 0;
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 16);
			1: return $urandom_range(0, 2);
			default: return 0;
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic rgbenc_pkg::cmd_t cmd_word(input logic [1:0] op, input int idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		rgbenc_pkg::cmd_t c;
		c.cmd = op;
		c.led_index = rgbenc_pkg::IDX_W'(idx);
		c.red = r;
		c.green = g;
		c.blue = b;
		return c;
	endfunction

	task automatic apply_command(input rgbenc_pkg::cmd_t c);
		rgbenc_pkg::pix_t p;
		case (c.cmd)
			rgbenc_pkg::CMD_SET: begin
				n_set++;
				if (int'(c.led_index) < LED_COUNT)
					strip[c.led_index] = {c.red, c.green, c.blue};
			end
			rgbenc_pkg::CMD_FILL: begin
				n_fill++;
				foreach (strip[i])
					strip[i] = {c.red, c.green, c.blue};
			end
			rgbenc_pkg::CMD_SHOW: begin
				n_show++;
				for (int i = 0; i < LED_COUNT; i++) begin
					p.pixel_number = rgbenc_pkg::IDX_W'(i);
					p.green_code = line_code(strip[i].green);
					p.red_code = line_code(strip[i].red);
					p.blue_code = line_code(strip[i].blue);
					p.last = (i == LED_COUNT - 1);
					pending_pixels.push_back(p);
				end
			end
			default: n_ignored++;
		endcase
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_data <= '0;
			send_gap <= 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				apply_command(cmd_data);
			if (!cmd_valid || !cmd_stall) begin
				if (send_gap != 0) begin
					cmd_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (queued_cmds.size() != 0) begin
					cmd_valid <= 1'b1;
					cmd_data <= queued_cmds.pop_front();
					send_gap <= draw_wait((n_offered / 40) % 3 == 1);
					n_offered <= n_offered + 1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// pixel monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_stall <= 1'b0;
			hold_cnt <= 0;
		end else if (pix_valid && !pix_stall) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t unexpected pixel transaction, expected none got %h", $time,
					pix_data);
			end else begin
				exp_pix = pending_pixels.pop_front();
				if (pix_data.pixel_number !== exp_pix.pixel_number) begin
					errors++;
					$display("%0t pixel_number expected %0d got %0d", $time,
						exp_pix.pixel_number, pix_data.pixel_number);
				end
				if (pix_data.green_code !== exp_pix.green_code) begin
					errors++;
					$display("%0t pixel %0d green_code expected %h got %h", $time,
						exp_pix.pixel_number, exp_pix.green_code, pix_data.green_code);
				end
				if (pix_data.red_code !== exp_pix.red_code) begin
					errors++;
					$display("%0t pixel %0d red_code expected %h got %h", $time,
						exp_pix.pixel_number, exp_pix.red_code, pix_data.red_code);
				end
				if (pix_data.blue_code !== exp_pix.blue_code) begin
					errors++;
					$display("%0t pixel %0d blue_code expected %h got %h", $time,
						exp_pix.pixel_number, exp_pix.blue_code, pix_data.blue_code);
				end
				if (pix_data.last !== exp_pix.last) begin
					errors++;
					$display("%0t pixel %0d last expected %b got %b", $time,
						exp_pix.pixel_number, exp_pix.last, pix_data.last);
				end
			end
			n_pixels++;
			// one long hold-off mid show so the command side backs up
			hold_len = (n_pixels == HOLD_AT) ? LONG_HOLD
				: draw_wait((n_pixels / 150) % 3 == 1);
			hold_cnt <= hold_len;
			pix_stall <= (hold_len != 0);
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			pix_stall <= (hold_cnt != 1);
		end
	end

	initial begin
		rgbenc_pkg::cmd_t c;
		int made;
		int pick;
		foreach (strip[i])
			strip[i] = '0;

		// cleared strip after reset, colour fields ignored by show
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SHOW, 63, 8'hFF, 8'hFF, 8'hFF));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SET, 0, 8'hFF, 8'hFF, 8'hFF));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SET, 63, 8'h00, 8'hFF, 8'h00));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SET, 1, 8'h80, 8'h01, 8'hAA));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SET, 62, 8'h55, 8'h7F, 8'hFE));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SET, 42, 8'h01, 8'h80, 8'h55));
		queued_cmds.push_back(cmd_word(CMD_UNUSED, 5, 8'hFF, 8'hFF, 8'hFF));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SHOW, 0, 8'h00, 8'h00, 8'h00));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_FILL, 17, 8'hFF, 8'hFF, 8'hFF));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SET, 31, 8'h00, 8'h00, 8'h00));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SHOW, 42, 8'h12, 8'h34, 8'h56));
		// clear is a fill with zero
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_FILL, 63, 8'h00, 8'h00, 8'h00));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SHOW, 21, 8'hA5, 8'h5A, 8'hC3));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_FILL, 0, 8'hA5, 8'h3C, 8'h0F));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SET, 32, 8'h7F, 8'hFE, 8'h81));
		queued_cmds.push_back(cmd_word(CMD_UNUSED, 63, 8'h00, 8'h00, 8'h00));
		queued_cmds.push_back(cmd_word(rgbenc_pkg::CMD_SHOW, 63, 8'hFF, 8'h00, 8'hFF));

		made = 0;
		while (made < RANDOM_CMDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				c.cmd = CMD_UNUSED;
			else if (pick < 68)
				c.cmd = rgbenc_pkg::CMD_SET;
			else if (pick < 80)
				c.cmd = rgbenc_pkg::CMD_FILL;
			else
				c.cmd = rgbenc_pkg::CMD_SHOW;
			c.led_index = rgbenc_pkg::IDX_W'($urandom);
			c.red = rand_byte();
			c.green = rand_byte();
			c.blue = rand_byte();
			if (c.cmd != CMD_UNUSED)
				made++;
			queued_cmds.push_back(c);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (queued_cmds.size() != 0 || cmd_valid)
			@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pixel writes, %0d fills, %0d shows, %0d unused commands",
			n_set, n_fill, n_show, n_ignored);
		$display("checked %0d encoded pixel transactions, %0d mismatches", n_pixels, errors);
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#(10 * TIMEOUT_CYCLES);
		$display("timeout with %0d pixel transactions outstanding", pending_pixels.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
sv/rgbenc_pkg.sv
sv/rgbenc_ram.sv
sv/rgb_led_strip_serial_encoder_unit.sv
verif/tb.sv
